/* design/sit_pkg.sv */
package sit_pkg;

	// result status codes
	localparam logic [2:0] ST_FOUND     = 3'd0;
	localparam logic [2:0] ST_INSERTED  = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_TOO_LONG  = 3'd4;

	localparam logic [31:0] CRC_POLY = 32'h82F63B78;
	localparam logic [31:0] CNT_MAX  = 32'hFFFFFFFF;

	typedef enum logic [3:0] {
		S_RECV,
		S_ENT_RD,
		S_ENT_CHK,
		S_CMP_RD,
		S_CMP_WAIT,
		S_CMP_CHK,
		S_HIT_RD,
		S_HIT_WAIT,
		S_COPY_RD,
		S_COPY_WAIT,
		S_COPY_WR,
		S_DONE
	} state_t;

	// one bit of the reflected crc-32c shift
	function automatic logic [31:0] crc_bit(input logic [31:0] c);
		crc_bit = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
	endfunction

	// one whole byte: eight dependent single-bit steps
	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) r = crc_bit(r);
		crc_byte = r;
	endfunction

endpackage

/* design/sit_ram.sv */
module sit_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

/* design/string_intern_table_top.sv */
// string interning dictionary
// s_axis: tdata = {mode, data_byte}, tlast marks the final byte of a string.
// m_axis: tdata = {use_total, status, entry_index}, one result per string.
// bytes are taken one per cycle while the block is receiving; a byte that is
// not final gives no result. on the final byte the block leaves receive and
// runs a sequencer that walks stored entries one at a time (read and check
// for each entry, then read, wait and check per compared byte for a candidate
// whose crc and length match, then hit read and hit wait on a hit), then copies
// a storable new string into the byte store with read, wait and write per byte.
// s_axis tready is low for all of that.
// the done state follows before the next byte is taken, and the registered
// byte ram reads set the per-byte steps.
// the result waits in an output register until taken; the next string is
// accepted only after the result is taken, so a stalled receiver stalls input.
// reset empties the table (fill counters only, no clearing pass) and clears
// the pending string.
module string_intern_table_top #(
	parameter int MAX_ENTRIES = 256,
	parameter int STORE_BYTES = 4096,
	parameter int MAX_LEN     = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // data_byte[7:0], mode[8], zero pad
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata   // entry_index[8:0], status[11:9], use_total[43:12]
);

	localparam int EW = $clog2(MAX_ENTRIES);
	localparam int SW = $clog2(STORE_BYTES);
	localparam int PW = $clog2(MAX_LEN) > 0 ? $clog2(MAX_LEN) : 1;
	localparam int LW = $clog2(MAX_LEN + 1);
	localparam int EF = $clog2(MAX_ENTRIES + 1);
	localparam int CF = $clog2(STORE_BYTES + 1);
	localparam int RW = 32 + LW + SW;

	sit_pkg::state_t state_q, state_d, state_x;

	logic [LW-1:0] plen_q;
	logic [31:0]   pcrc_q;
	logic          povf_q;
	logic          mode_q;
	logic [EF-1:0] efill_q;
	logic [CF-1:0] cfill_q;
	logic [EW-1:0] eidx_q;
	logic [LW-1:0] k_q;
	logic          out_v_q;
	logic [8:0]    out_idx_q;
	logic [2:0]    out_st_q;
	logic [31:0]   out_tot_q;

	logic          acc;
	logic [7:0]    data_byte;

	// pending buffer
	logic          pb_we;
	logic [PW-1:0] pb_waddr, pb_raddr;
	logic [7:0]    pb_rdata;
	// byte store
	logic          cs_we;
	logic [SW-1:0] cs_waddr, cs_raddr;
	logic [7:0]    cs_rdata;
	// entry record {crc, len, offset}
	logic          er_we;
	logic [EW-1:0] er_raddr;
	logic [RW-1:0] er_wdata, er_rdata;
	// use counts
	logic          uc_we;
	logic [EW-1:0] uc_waddr, uc_raddr;
	logic [31:0]   uc_wdata, uc_rdata;

	logic [31:0]   e_crc;
	logic [LW-1:0] e_len;
	logic [SW-1:0] e_off;
	logic [31:0]   fin_crc;
	logic [CF-1:0] room;

	// end-of-search decisions
	logic          miss_now, ovf_now, ins_go, miss_res, copy_last, res_now;
	logic          mode_q_eff;
	logic [LW-1:0] plen_eff;

	assign data_byte = s_axis_tdata[7:0];
	assign acc = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == sit_pkg::S_RECV) && !out_v_q;
	assign {e_crc, e_len, e_off} = er_rdata;
	assign fin_crc = ~pcrc_q;
	assign room = CF'(STORE_BYTES) - cfill_q;

	sit_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_pend (
		.clk(clk), .we(pb_we), .waddr(pb_waddr), .wdata(data_byte),
		.raddr(pb_raddr), .rdata(pb_rdata));
	sit_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_chars (
		.clk(clk), .we(cs_we), .waddr(cs_waddr), .wdata(pb_rdata),
		.raddr(cs_raddr), .rdata(cs_rdata));
	sit_ram #(.WIDTH(RW), .DEPTH(MAX_ENTRIES)) u_ents (
		.clk(clk), .we(er_we), .waddr(efill_q[EW-1:0]), .wdata(er_wdata),
		.raddr(er_raddr), .rdata(er_rdata));
	sit_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_uses (
		.clk(clk), .we(uc_we), .waddr(uc_waddr), .wdata(uc_wdata),
		.raddr(uc_raddr), .rdata(uc_rdata));

	assign pb_we    = acc && (plen_q < LW'(MAX_LEN));
	assign pb_waddr = plen_q[PW-1:0];
	assign pb_raddr = k_q[PW-1:0];
	assign cs_raddr = SW'(e_off + SW'(k_q));
	assign cs_waddr = SW'(cfill_q[SW-1:0] + SW'(k_q));
	assign er_raddr = eidx_q;
	assign er_wdata = {fin_crc, plen_q, cfill_q[SW-1:0]};
	assign uc_raddr = eidx_q;

	// sequencer: next state and write strobes
	always_comb begin
		state_d  = state_q;
		cs_we    = 1'b0;
		er_we    = 1'b0;
		uc_we    = 1'b0;
		uc_waddr = eidx_q;
		uc_wdata = 32'd1;
		case (state_q)
			sit_pkg::S_RECV: begin
				if (acc && s_axis_tlast) begin
					if (povf_q || plen_q == LW'(MAX_LEN)) state_d = sit_pkg::S_DONE;
					else if (efill_q == '0) state_d = sit_pkg::S_DONE;
					else state_d = sit_pkg::S_ENT_RD;
				end
			end
			sit_pkg::S_ENT_RD: state_d = sit_pkg::S_ENT_CHK;
			sit_pkg::S_ENT_CHK: begin
				if (e_crc == fin_crc && e_len == plen_q) state_d = sit_pkg::S_CMP_RD;
				else if (EF'(eidx_q) + EF'(1) >= efill_q) state_d = sit_pkg::S_DONE;
				else state_d = sit_pkg::S_ENT_RD;
			end
			sit_pkg::S_CMP_RD: state_d = sit_pkg::S_CMP_WAIT;
			sit_pkg::S_CMP_WAIT: state_d = sit_pkg::S_CMP_CHK;
			sit_pkg::S_CMP_CHK: begin
				if (cs_rdata != pb_rdata) begin
					if (EF'(eidx_q) + EF'(1) >= efill_q) state_d = sit_pkg::S_DONE;
					else state_d = sit_pkg::S_ENT_RD;
				end else if (k_q + LW'(1) >= plen_q) state_d = sit_pkg::S_HIT_RD;
				else state_d = sit_pkg::S_CMP_RD;
			end
			sit_pkg::S_HIT_RD: state_d = sit_pkg::S_HIT_WAIT;
			sit_pkg::S_HIT_WAIT: begin
				uc_we    = !mode_q && uc_rdata != sit_pkg::CNT_MAX;
				uc_wdata = uc_rdata + 32'd1;
				state_d  = sit_pkg::S_DONE;
			end
			sit_pkg::S_COPY_RD: state_d = sit_pkg::S_COPY_WAIT;
			sit_pkg::S_COPY_WAIT: state_d = sit_pkg::S_COPY_WR;
			sit_pkg::S_COPY_WR: begin
				cs_we = 1'b1;
				if (k_q + LW'(1) >= plen_q) begin
					er_we    = 1'b1;
					uc_we    = 1'b1;
					uc_waddr = efill_q[EW-1:0];
					state_d  = sit_pkg::S_DONE;
				end else state_d = sit_pkg::S_COPY_RD;
			end
			sit_pkg::S_DONE: state_d = sit_pkg::S_RECV;
			default: state_d = sit_pkg::S_RECV;
		endcase
	end

	// miss handling: a search that ends without a hit
	assign ovf_now  = state_q == sit_pkg::S_RECV && acc && s_axis_tlast
		&& (povf_q || plen_q == LW'(MAX_LEN));
	assign miss_now = state_d == sit_pkg::S_DONE && !ovf_now
		&& state_q != sit_pkg::S_HIT_WAIT && state_q != sit_pkg::S_COPY_WR
		&& state_q != sit_pkg::S_DONE;
	assign mode_q_eff = (state_q == sit_pkg::S_RECV) ? s_axis_tdata[8] : mode_q;
	assign plen_eff   = (state_q == sit_pkg::S_RECV) ? plen_q + LW'(1) : plen_q;
	assign ins_go = miss_now && !mode_q_eff
		&& efill_q < EF'(MAX_ENTRIES) && CF'(plen_eff) <= room;
	assign miss_res  = miss_now && !ins_go;
	assign copy_last = state_q == sit_pkg::S_COPY_WR && k_q + LW'(1) >= plen_q;
	assign res_now   = ovf_now || miss_res || state_q == sit_pkg::S_HIT_WAIT || copy_last;

	// a miss that can be stored goes to the copy instead of done
	always_comb begin
		state_x = state_d;
		if (ins_go) state_x = sit_pkg::S_COPY_RD;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= sit_pkg::S_RECV;
		else state_q <= state_x;
	end

	// datapath and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q    <= '0;
			pcrc_q    <= '1;
			povf_q    <= 1'b0;
			mode_q    <= 1'b0;
			efill_q   <= '0;
			cfill_q   <= '0;
			eidx_q    <= '0;
			k_q       <= '0;
			out_v_q   <= 1'b0;
			out_idx_q <= '0;
			out_st_q  <= '0;
			out_tot_q <= '0;
		end else begin
			case (state_q)
				sit_pkg::S_RECV: begin
					if (acc) begin
						mode_q <= s_axis_tdata[8];
						eidx_q <= '0;
						k_q    <= '0;
						if (plen_q < LW'(MAX_LEN)) begin
							plen_q <= plen_q + LW'(1);
							pcrc_q <= sit_pkg::crc_byte(pcrc_q, data_byte);
						end else povf_q <= 1'b1;
					end
				end
				sit_pkg::S_ENT_CHK: begin
					k_q <= '0;
					if (!(e_crc == fin_crc && e_len == plen_q))
						eidx_q <= EW'(EF'(eidx_q) + EF'(1));
				end
				sit_pkg::S_CMP_CHK: begin
					if (cs_rdata != pb_rdata) begin
						k_q    <= '0;
						eidx_q <= EW'(EF'(eidx_q) + EF'(1));
					end else k_q <= k_q + LW'(1);
				end
				sit_pkg::S_COPY_WR: k_q <= k_q + LW'(1);
				default: ;
			endcase
			case (state_q)
				sit_pkg::S_DONE: begin
					plen_q <= '0;
					pcrc_q <= '1;
					povf_q <= 1'b0;
				end
				default: ;
			endcase
			// result valid: set when a result is ready (too long, miss, hit or insert), held until taken
			if (res_now) out_v_q <= 1'b1;
			else if (m_axis_tready) out_v_q <= 1'b0;
			if (ovf_now || miss_res) begin
				out_idx_q <= '0;
				out_tot_q <= '0;
				if (ovf_now) out_st_q <= sit_pkg::ST_TOO_LONG;
				else out_st_q <= mode_q_eff ? sit_pkg::ST_NOT_FOUND : sit_pkg::ST_FULL;
			end
			if (state_q == sit_pkg::S_HIT_WAIT) begin
				out_idx_q <= 9'(EF'(eidx_q) + EF'(1));
				out_st_q  <= sit_pkg::ST_FOUND;
				out_tot_q <= (!mode_q && uc_rdata != sit_pkg::CNT_MAX)
					? uc_rdata + 32'd1 : uc_rdata;
			end
			if (copy_last) begin
				out_idx_q <= 9'(efill_q + EF'(1));
				out_st_q  <= sit_pkg::ST_INSERTED;
				out_tot_q <= 32'd1;
				efill_q   <= efill_q + EF'(1);
				cfill_q   <= cfill_q + CF'(plen_q);
			end
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {4'd0, out_tot_q, out_st_q, out_idx_q};

	// property checks
	property p_fill_bounded;
		@(posedge clk) disable iff (!arst_n) efill_q <= EF'(MAX_ENTRIES);
	endproperty
	a_fill_bounded: assert property (p_fill_bounded) else $error("entry fill overrun");

	property p_store_bounded;
		@(posedge clk) disable iff (!arst_n) cfill_q <= CF'(STORE_BYTES);
	endproperty
	a_store_bounded: assert property (p_store_bounded) else $error("byte store overrun");

	property p_no_accept_busy;
		@(posedge clk) disable iff (!arst_n) m_axis_tvalid |-> !s_axis_tready;
	endproperty
	a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while result held");

endmodule
